// ----- hw/rtl/elv_pkg.sv -----
// Shared types and constants for the elevator dispatch controller.
// No dependencies; compiled first.
package elv_pkg;

  localparam int unsigned FLOOR_COUNT_DEF = 16;
  localparam int unsigned START_LEVEL_DEF = 1;

  localparam int unsigned FLOOR_W = 5;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned OP_W    = 2;

  localparam logic [OP_W-1:0] OP_CALL   = 2'd0;
  localparam logic [OP_W-1:0] OP_ARRIVE = 2'd1;
  localparam logic [OP_W-1:0] OP_PASS   = 2'd2;

  localparam logic [DIR_W-1:0] DIR_STAND = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_TGT,
    ST_SCAN_NXT,
    ST_EMIT
  } state_t;

  // Broadcast from the controller to every floor cell.
  typedef struct packed {
    logic               pend_set;
    logic               pend_clr;
    logic [FLOOR_W-1:0] pend_floor;
    logic               tok_load;
    logic [FLOOR_W-1:0] tok_floor;
    logic               tok_step;
    logic               tok_up;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/elv_ifs.sv -----
// Valid/ready channel interfaces for floor events and car commands.
// Depends on elv_pkg for field widths.
interface elv_in_if;
  logic                       valid;
  logic                       ready;
  logic [elv_pkg::OP_W-1:0]    opcode;
  logic [elv_pkg::FLOOR_W-1:0] floor;

  modport source (output valid, output opcode, output floor, input ready);
  modport sink   (input valid, input opcode, input floor, output ready);
endinterface

interface elv_out_if;
  logic                       valid;
  logic                       ready;
  logic [elv_pkg::FLOOR_W-1:0] target_floor;
  logic [elv_pkg::DIR_W-1:0]   move_direction;

  modport source (output valid, output target_floor, output move_direction, input ready);
  modport sink   (input valid, input target_floor, input move_direction, output ready);
endinterface

// ----- hw/rtl/elv_cell.sv -----
// One floor cell: holds the floor's pending request bit and a scan token
// that moves one cell per cycle while the controller steps it. Depends on elv_pkg.
module elv_cell #(
  parameter int unsigned CELL_FLOOR = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  elv_pkg::cell_ctl_t ctl,
  input  logic               tok_below,
  input  logic               tok_above,
  output logic               tok,
  output logic               hit
);
  import elv_pkg::*;

  localparam logic [FLOOR_W-1:0] MY_FLOOR = FLOOR_W'(CELL_FLOOR);

  logic pend_r, pend_nxt;
  logic tok_r, tok_nxt;

  always_comb begin
    pend_nxt = pend_r;
    if (ctl.pend_set && ctl.pend_floor == MY_FLOOR) begin
      pend_nxt = 1'b1;
    end else if (ctl.pend_clr && ctl.pend_floor == MY_FLOOR) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    tok_nxt = tok_r;
    if (ctl.tok_load) begin
      tok_nxt = (ctl.tok_floor == MY_FLOOR);
    end else if (ctl.tok_step) begin
      tok_nxt = ctl.tok_up ? tok_below : tok_above;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok = tok_r;
  assign hit = tok_r & pend_r;

endmodule

// ----- hw/rtl/elv_ctrl.sv -----
// Dispatch sequencer: decodes floor events, runs token scans over the cell
// row and registers car commands. Depends on elv_pkg and elv_ifs.
module elv_ctrl #(
  parameter int unsigned FLOOR_COUNT = elv_pkg::FLOOR_COUNT_DEF,
  parameter int unsigned START_LEVEL = elv_pkg::START_LEVEL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  elv_in_if.sink              in_ch,
  elv_out_if.source           out_ch,
  input  logic                hit_any,
  output elv_pkg::cell_ctl_t  ctl
);
  import elv_pkg::*;

  localparam logic [FLOOR_W-1:0] FC       = FLOOR_W'(FLOOR_COUNT);
  localparam logic [FLOOR_W-1:0] START_FL = FLOOR_W'(START_LEVEL);
  localparam logic [FLOOR_W-1:0] FL_ONE   = FLOOR_W'(1);
  localparam logic [FLOOR_W-1:0] FL_NONE  = '0;

  state_t             state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [FLOOR_W-1:0] fl_r, fl_nxt;
  logic [FLOOR_W-1:0] car_r, car_nxt;
  logic [FLOOR_W-1:0] final_r, final_nxt;
  logic [DIR_W-1:0]   heading_r, heading_nxt;
  logic               busy_r, busy_nxt;
  logic [FLOOR_W-1:0] pos_r, pos_nxt;
  logic               scan_up_r, scan_up_nxt;
  logic [FLOOR_W-1:0] res_floor_r, res_floor_nxt;
  logic [DIR_W-1:0]   res_dir_r, res_dir_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FLOOR_W-1:0] out_floor_r, out_floor_nxt;
  logic [DIR_W-1:0]   out_dir_r, out_dir_nxt;

  logic fl_ok;
  logic scan_end;
  logic out_free;
  logic [FLOOR_W-1:0] tgt;
  logic [DIR_W-1:0]   hd;

  assign fl_ok    = (fl_r != FL_NONE) && (fl_r <= FC);
  assign scan_end = (pos_r == (scan_up_r ? FC : FL_ONE));
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.target_floor   = out_floor_r;
  assign out_ch.move_direction = out_dir_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        if (fl_ok) begin
          case (op_r)
            OP_CALL:   state_nxt = ST_EMIT;
            OP_ARRIVE: begin
              if (busy_r) state_nxt = (fl_r == final_r) ? ST_SCAN_TGT : ST_SCAN_NXT;
            end
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_TGT: begin
        if (hit_any || scan_end) state_nxt = ST_SCAN_NXT;
      end
      ST_SCAN_NXT: begin
        if (hit_any) state_nxt = ST_EMIT;
        else if (scan_end) state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and cell control
  always_comb begin
    op_nxt        = op_r;
    fl_nxt        = fl_r;
    car_nxt       = car_r;
    final_nxt     = final_r;
    heading_nxt   = heading_r;
    busy_nxt      = busy_r;
    pos_nxt       = pos_r;
    scan_up_nxt   = scan_up_r;
    res_floor_nxt = res_floor_r;
    res_dir_nxt   = res_dir_r;
    out_valid_nxt = out_valid_r;
    out_floor_nxt = out_floor_r;
    out_dir_nxt   = out_dir_r;
    ctl           = '0;
    tgt           = FL_NONE;
    hd            = heading_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt = in_ch.opcode;
          fl_nxt = in_ch.floor;
        end
      end
      ST_EXEC: begin
        if (fl_ok) begin
          case (op_r)
            OP_CALL: begin
              busy_nxt       = 1'b1;
              ctl.pend_set   = 1'b1;
              ctl.pend_floor = fl_r;
              if (final_r == FL_NONE) begin
                final_nxt = fl_r;
                hd        = (car_r > fl_r) ? DIR_DOWN : DIR_UP;
              end else if (heading_r == DIR_UP && fl_r > final_r) begin
                final_nxt = fl_r;
              end else if (heading_r == DIR_DOWN && fl_r < final_r) begin
                final_nxt = fl_r;
              end
              heading_nxt   = hd;
              res_floor_nxt = fl_r;
              res_dir_nxt   = hd;
            end
            OP_ARRIVE: begin
              if (busy_r) begin
                car_nxt        = fl_r;
                ctl.pend_clr   = 1'b1;
                ctl.pend_floor = fl_r;
                ctl.tok_load   = 1'b1;
                if (fl_r == final_r) begin
                  // retarget: highest pending when going up, else lowest
                  scan_up_nxt   = (heading_r != DIR_UP);
                  pos_nxt       = (heading_r != DIR_UP) ? FL_ONE : FC;
                  ctl.tok_floor = (heading_r != DIR_UP) ? FL_ONE : FC;
                end else begin
                  scan_up_nxt   = (final_r > fl_r);
                  pos_nxt       = fl_r;
                  ctl.tok_floor = fl_r;
                end
              end
            end
            OP_PASS: car_nxt = fl_r;
            default: ;
          endcase
        end
      end
      ST_SCAN_TGT: begin
        if (hit_any || scan_end) begin
          tgt           = hit_any ? pos_r : FL_NONE;
          final_nxt     = tgt;
          scan_up_nxt   = (tgt > car_r);
          pos_nxt       = car_r;
          ctl.tok_load  = 1'b1;
          ctl.tok_floor = car_r;
        end else begin
          ctl.tok_step = 1'b1;
          ctl.tok_up   = scan_up_r;
          pos_nxt      = scan_up_r ? pos_r + FL_ONE : pos_r - FL_ONE;
        end
      end
      ST_SCAN_NXT: begin
        if (hit_any) begin
          hd            = (car_r > final_r) ? DIR_DOWN : DIR_UP;
          heading_nxt   = hd;
          res_floor_nxt = pos_r;
          res_dir_nxt   = hd;
        end else if (scan_end) begin
          busy_nxt = 1'b0;
        end else begin
          ctl.tok_step = 1'b1;
          ctl.tok_up   = scan_up_r;
          pos_nxt      = scan_up_r ? pos_r + FL_ONE : pos_r - FL_ONE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_floor_nxt = res_floor_r;
          out_dir_nxt   = res_dir_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      car_r       <= START_FL;
      final_r     <= FL_NONE;
      heading_r   <= DIR_STAND;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      car_r       <= car_nxt;
      final_r     <= final_nxt;
      heading_r   <= heading_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    fl_r        <= fl_nxt;
    pos_r       <= pos_nxt;
    scan_up_r   <= scan_up_nxt;
    res_floor_r <= res_floor_nxt;
    res_dir_r   <= res_dir_nxt;
    out_floor_r <= out_floor_nxt;
    out_dir_r   <= out_dir_nxt;
  end

endmodule

// ----- hw/rtl/elevator_dispatch_controller.sv -----
// Events: a call sets its floor's request and queues its command; an arrival
// while busy at the destination runs a retarget scan, then a nearest-request
// scan, the token walking cell by cell; other such arrivals run only the latter.
// Throughput: one event at a time; the next beat is taken once the command is
// in the output register or the event ends. Synchronous active-low reset:
// requests clear, car at START_LEVEL, no destination, standing, free.
module elevator_dispatch_controller #(
  parameter int unsigned FLOOR_COUNT = elv_pkg::FLOOR_COUNT_DEF,
  parameter int unsigned START_LEVEL = elv_pkg::START_LEVEL_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  elv_in_if.sink    in_ch,
  elv_out_if.source out_ch
);
  import elv_pkg::*;

  cell_ctl_t              ctl;
  logic [FLOOR_COUNT+1:0] tok_pad;
  logic [FLOOR_COUNT-1:0] hit_vec;
  logic                   hit_any;

  assign tok_pad[0]             = 1'b0;
  assign tok_pad[FLOOR_COUNT+1] = 1'b0;
  assign hit_any                = |hit_vec;

  elv_ctrl #(
    .FLOOR_COUNT(FLOOR_COUNT),
    .START_LEVEL(START_LEVEL)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .hit_any(hit_any),
    .ctl    (ctl)
  );

  for (genvar i = 0; i < FLOOR_COUNT; i++) begin : g_cell
    elv_cell #(
      .CELL_FLOOR(i + 1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .tok_below(tok_pad[i]),
      .tok_above(tok_pad[i+2]),
      .tok      (tok_pad[i+1]),
      .hit      (hit_vec[i])
    );
  end

endmodule

// ----- hw/rtl/elv_checker.sv -----
// Port-level checks for the elevator dispatch controller, bound to the top.
// Depends on elv_pkg.
module elv_checker #(
  parameter int unsigned FLOOR_COUNT = elv_pkg::FLOOR_COUNT_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [elv_pkg::FLOOR_W-1:0] out_target,
  input logic [elv_pkg::DIR_W-1:0]   out_dir
);
  import elv_pkg::*;

  localparam logic [FLOOR_W-1:0] FC = FLOOR_W'(FLOOR_COUNT);

  // a stalled command beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_target) && $stable(out_dir)))
    else $error("command beat changed while stalled");

  // one event at a time: ready drops right after a beat is taken
  a_one_event: assert property (@(posedge clk)
    (rst_n && in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an event is in progress");

  // a new command is only loaded while the input side is closed
  a_emit_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("command appeared without an event in progress");

  a_cmd_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_dir == DIR_UP || out_dir == DIR_DOWN) &&
                   out_target != '0 && out_target <= FC))
    else $error("command floor or direction out of range");

endmodule

bind elevator_dispatch_controller elv_checker #(
  .FLOOR_COUNT(FLOOR_COUNT)
) u_elv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_target(out_ch.target_floor),
  .out_dir   (out_ch.move_direction)
);
